[rtl/core/ifr_pkg.sv]
// ----------------------------------------------------------------------------
// ifr_pkg
// types and constants of the ipv4 fragment reassembly tracker
// ----------------------------------------------------------------------------
package ifr_pkg;

  localparam logic [1:0] FUNC_FRAG   = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_LAST  = 2'd1;
  localparam logic [1:0] MODE_LINUX = 2'd2;

  localparam logic [1:0] STATUS_NONE = 2'd0;
  localparam logic [1:0] STATUS_FRAG = 2'd1;
  localparam logic [1:0] STATUS_DONE = 2'd2;

  localparam logic [16:0] MAX_END = 17'd65535;

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001,
    S_KRD  = 19'h00002,
    S_KCMP = 19'h00004,
    S_MRD  = 19'h00008,
    S_MLD  = 19'h00010,
    S_WRD  = 19'h00020,
    S_WCHK = 19'h00040,
    S_DEC  = 19'h00080,
    S_GRD  = 19'h00100,
    S_GCHK = 19'h00200,
    S_PLAN = 19'h00400,
    S_MVRD = 19'h00800,
    S_MVWR = 19'h01000,
    S_PUT  = 19'h02000,
    S_CHK0 = 19'h04000,
    S_CRD  = 19'h08000,
    S_CCHK = 19'h10000,
    S_FIN  = 19'h20000,
    S_OUT  = 19'h40000
  } state_t;

endpackage

[rtl/core/ifr_ram.sv]
// ----------------------------------------------------------------------------
// ifr_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module ifr_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/ipv4_fragment_reassembly_tracker.sv]
// ----------------------------------------------------------------------------
// ipv4_fragment_reassembly_tracker
// per-stream sorted fragment tables with selectable overlap policy
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid/in_ready    func, key, offset, length, mf
//  out      output     out_valid/out_ready  status, length, slot, flags
//  cfg      input      cfg_valid/cfg_ready  overlap_mode
//
//  one word at a time; key search reads the stream slots one by one
//  each walk, scan, move and gap check steps through the table entries,
//  all on the single fragment ram port pair
//  in_ready is low from accept until the result word is taken
//  synchronous active-low reset clears stream valid bits and the mode
// ----------------------------------------------------------------------------
module ipv4_fragment_reassembly_tracker #(
  parameter int STREAMS = 16,
  parameter int FRAGS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic        in_has_ip_payload,
  input  logic [15:0] in_ident,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  input  logic [12:0] in_frag_offset,
  input  logic [15:0] in_payload_len,
  input  logic        in_more_fragments,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [16:0] out_total_length,
  output logic [7:0]  out_stream_slot,
  output logic        out_corrupt_dropped,
  output logic        out_table_full,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_overlap_mode
);

  localparam int SW  = (STREAMS > 1) ? $clog2(STREAMS) : 1;
  localparam int FW  = $clog2(FRAGS);
  localparam int CW  = $clog2(FRAGS + 1);
  localparam int BW  = 16 + CW;
  localparam int FAW = SW + FW;
  localparam int KW  = 80;
  localparam int MW  = CW + BW + 17 + 1;

  ifr_pkg::state_t state_r, state_nxt;

  logic [1:0]   mode_r, mode_nxt;
  logic [1:0]   func_r, func_nxt;
  logic         mf_r, mf_nxt;
  logic [15:0]  id_r, id_nxt;
  logic [31:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [15:0]  off_r, off_nxt, plen_r, plen_nxt;
  logic [STREAMS-1:0] valid_r, valid_nxt;
  logic [SW-1:0] k_r, k_nxt, slot_r, slot_nxt, free_r, free_nxt;
  logic         free_found_r, free_found_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, pos_r, pos_nxt, j_r, j_nxt, gone_r, gone_nxt;
  logic [BW-1:0] bytes_r, bytes_nxt, removed_r, removed_nxt;
  logic [16:0]  total_r, total_nxt, prev_end_r, prev_end_nxt, e_r, e_nxt, exp_r, exp_nxt;
  logic         last_r, last_nxt, have_cur_r, have_cur_nxt;
  logic [15:0]  cur_start_r, cur_start_nxt, cur_len_r, cur_len_nxt;
  logic [15:0]  st_r, st_nxt, ln_r, ln_nxt;
  logic         trim_en_r, trim_en_nxt, up_r, up_nxt;
  logic         done_r, done_nxt, corrupt_r, corrupt_nxt, full_r, full_nxt;
  logic [1:0]   o_status_r, o_status_nxt;
  logic [16:0]  o_total_r, o_total_nxt;
  logic [7:0]   o_slot_r, o_slot_nxt;
  logic         o_corrupt_r, o_corrupt_nxt, o_full_r, o_full_nxt;

  logic           key_we;
  logic [SW-1:0]  key_raddr;
  logic [KW-1:0]  key_rdata;
  logic           meta_we;
  logic [MW-1:0]  meta_rdata;
  logic           frag_we;
  logic [FAW-1:0] frag_waddr, frag_raddr;
  logic [31:0]    frag_wdata, frag_rdata;

  logic [15:0] rd_start, rd_len;
  logic [16:0] rd_end;
  logic        key_hit;
  logic [SW-1:0] free_now;
  logic [16:0] diff, e_new, st_new, tr_amt17;
  logic [15:0] amt, tr_amt;
  logic [CW-1:0] dst;

  assign rd_start = frag_rdata[31:16];
  assign rd_len   = frag_rdata[15:0];
  assign rd_end   = {1'b0, rd_start} + {1'b0, rd_len};
  assign key_hit  = valid_r[k_r] && (key_rdata == {id_r, lo_r, hi_r});
  assign free_now = free_found_r ? free_r : k_r;
  assign diff     = prev_end_r - {1'b0, off_r};
  assign amt      = (prev_end_r > {1'b0, off_r}) ?
                    ((diff > {1'b0, plen_r}) ? plen_r : diff[15:0]) : 16'd0;
  assign st_new   = {1'b0, off_r} + {1'b0, amt};
  assign e_new    = {1'b0, off_r} + {1'b0, plen_r};
  assign tr_amt17 = e_r - {1'b0, rd_start};
  assign tr_amt   = (tr_amt17 > {1'b0, rd_len}) ? rd_len : tr_amt17[15:0];
  assign dst      = j_r + CW'(1) - gone_r;

  assign frag_raddr = (state_r == ifr_pkg::S_WRD) ? {slot_r, pos_r[FW-1:0]}
                                                  : {slot_r, j_r[FW-1:0]};
  assign key_raddr  = k_r;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    func_nxt       = func_r;
    mf_nxt         = mf_r;
    id_nxt         = id_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    off_nxt        = off_r;
    plen_nxt       = plen_r;
    valid_nxt      = valid_r;
    k_nxt          = k_r;
    slot_nxt       = slot_r;
    free_nxt       = free_r;
    free_found_nxt = free_found_r;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    j_nxt          = j_r;
    gone_nxt       = gone_r;
    bytes_nxt      = bytes_r;
    removed_nxt    = removed_r;
    total_nxt      = total_r;
    prev_end_nxt   = prev_end_r;
    e_nxt          = e_r;
    exp_nxt        = exp_r;
    last_nxt       = last_r;
    have_cur_nxt   = have_cur_r;
    cur_start_nxt  = cur_start_r;
    cur_len_nxt    = cur_len_r;
    st_nxt         = st_r;
    ln_nxt         = ln_r;
    trim_en_nxt    = trim_en_r;
    up_nxt         = up_r;
    done_nxt       = done_r;
    corrupt_nxt    = corrupt_r;
    full_nxt       = full_r;
    o_status_nxt   = o_status_r;
    o_total_nxt    = o_total_r;
    o_slot_nxt     = o_slot_r;
    o_corrupt_nxt  = o_corrupt_r;
    o_full_nxt     = o_full_r;
    key_we         = 1'b0;
    meta_we        = 1'b0;
    frag_we        = 1'b0;
    frag_waddr     = {slot_r, pos_r[FW-1:0]};
    frag_wdata     = {st_r, ln_r};

    if (cfg_valid) begin
      mode_nxt = cfg_overlap_mode;
    end

    unique case (state_r)
      ifr_pkg::S_IDLE: begin
        if (in_valid) begin
          func_nxt      = in_func;
          mf_nxt        = in_more_fragments;
          id_nxt        = in_ident;
          lo_nxt        = (in_src_addr < in_dst_addr) ? in_src_addr : in_dst_addr;
          hi_nxt        = (in_src_addr < in_dst_addr) ? in_dst_addr : in_src_addr;
          off_nxt       = {in_frag_offset, 3'b000};
          plen_nxt      = in_payload_len;
          k_nxt         = '0;
          free_found_nxt = 1'b0;
          done_nxt      = 1'b0;
          corrupt_nxt   = 1'b0;
          full_nxt      = 1'b0;
          o_status_nxt  = ifr_pkg::STATUS_NONE;
          o_total_nxt   = '0;
          o_slot_nxt    = '0;
          o_corrupt_nxt = 1'b0;
          o_full_nxt    = 1'b0;
          if (in_func == ifr_pkg::FUNC_CLEAR) begin
            valid_nxt = '0;
            state_nxt = ifr_pkg::S_OUT;
          end else if (in_func == ifr_pkg::FUNC_REMOVE) begin
            state_nxt = ifr_pkg::S_KRD;
          end else if (in_func == ifr_pkg::FUNC_FRAG && in_has_ip_payload &&
                       (in_more_fragments || in_frag_offset != 13'd0)) begin
            state_nxt = ifr_pkg::S_KRD;
          end else begin
            state_nxt = ifr_pkg::S_OUT;
          end
        end
      end
      ifr_pkg::S_KRD: begin
        state_nxt = ifr_pkg::S_KCMP;
      end
      ifr_pkg::S_KCMP: begin
        if (!valid_r[k_r] && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_nxt       = k_r;
        end
        if (key_hit) begin
          slot_nxt = k_r;
          if (func_r == ifr_pkg::FUNC_REMOVE) begin
            valid_nxt[k_r] = 1'b0;
            o_slot_nxt     = 8'(k_r);
            state_nxt      = ifr_pkg::S_OUT;
          end else begin
            state_nxt = ifr_pkg::S_MRD;
          end
        end else if (k_r == SW'(STREAMS - 1)) begin
          if (func_r == ifr_pkg::FUNC_REMOVE) begin
            state_nxt = ifr_pkg::S_OUT;
          end else if (free_found_r || !valid_r[k_r]) begin
            slot_nxt            = free_now;
            valid_nxt[free_now] = 1'b1;
            key_we              = 1'b1;
            cnt_nxt             = '0;
            bytes_nxt           = '0;
            total_nxt           = '0;
            last_nxt            = 1'b0;
            pos_nxt             = '0;
            prev_end_nxt        = '0;
            state_nxt           = ifr_pkg::S_WRD;
          end else begin
            o_status_nxt = ifr_pkg::STATUS_FRAG;
            o_full_nxt   = 1'b1;
            state_nxt    = ifr_pkg::S_OUT;
          end
        end else begin
          k_nxt     = k_r + SW'(1);
          state_nxt = ifr_pkg::S_KRD;
        end
      end
      ifr_pkg::S_MRD: begin
        state_nxt = ifr_pkg::S_MLD;
      end
      ifr_pkg::S_MLD: begin
        {cnt_nxt, bytes_nxt, total_nxt, last_nxt} = meta_rdata;
        pos_nxt      = '0;
        prev_end_nxt = '0;
        state_nxt    = ifr_pkg::S_WRD;
      end
      ifr_pkg::S_WRD: begin
        if (pos_r < cnt_r) begin
          state_nxt = ifr_pkg::S_WCHK;
        end else begin
          have_cur_nxt = 1'b0;
          state_nxt    = ifr_pkg::S_DEC;
        end
      end
      ifr_pkg::S_WCHK: begin
        if (off_r > rd_start) begin
          prev_end_nxt = rd_end;
          pos_nxt      = pos_r + CW'(1);
          state_nxt    = ifr_pkg::S_WRD;
        end else begin
          have_cur_nxt  = 1'b1;
          cur_start_nxt = rd_start;
          cur_len_nxt   = rd_len;
          state_nxt     = ifr_pkg::S_DEC;
        end
      end
      ifr_pkg::S_DEC: begin
        gone_nxt    = '0;
        removed_nxt = '0;
        j_nxt       = pos_r;
        e_nxt       = e_new;
        state_nxt   = ifr_pkg::S_CHK0;
        if (mode_r == ifr_pkg::MODE_LINUX) begin
          if (have_cur_r && cur_start_r == off_r && cur_len_r == plen_r) begin
            if (!mf_r) begin
              total_nxt = e_new;
              last_nxt  = 1'b1;
            end
          end else if (amt != plen_r && e_new <= ifr_pkg::MAX_END) begin
            st_nxt      = st_new[15:0];
            ln_nxt      = plen_r - amt;
            trim_en_nxt = 1'b1;
            state_nxt   = ifr_pkg::S_GRD;
          end
        end else begin
          if (have_cur_r && cur_start_r == off_r) begin
            if (mode_r == ifr_pkg::MODE_LAST) begin
              bytes_nxt  = bytes_r - BW'(cur_len_r) + BW'(plen_r);
              frag_we    = 1'b1;
              frag_wdata = {off_r, plen_r};
              if (!mf_r) begin
                total_nxt = e_new;
                last_nxt  = 1'b1;
              end
            end
          end else begin
            st_nxt      = off_r;
            ln_nxt      = plen_r;
            trim_en_nxt = 1'b0;
            state_nxt   = ifr_pkg::S_PLAN;
          end
        end
      end
      ifr_pkg::S_GRD: begin
        state_nxt = (j_r < cnt_r) ? ifr_pkg::S_GCHK : ifr_pkg::S_PLAN;
      end
      ifr_pkg::S_GCHK: begin
        if ({1'b0, rd_start} < e_r && rd_end <= e_r) begin
          gone_nxt    = gone_r + CW'(1);
          removed_nxt = removed_r + BW'(rd_len);
          j_nxt       = j_r + CW'(1);
          state_nxt   = ifr_pkg::S_GRD;
        end else begin
          state_nxt = ifr_pkg::S_PLAN;
        end
      end
      ifr_pkg::S_PLAN: begin
        if ((cnt_r - gone_r) >= CW'(FRAGS)) begin
          full_nxt  = 1'b1;
          state_nxt = ifr_pkg::S_FIN;
        end else begin
          bytes_nxt = bytes_r - removed_r;
          if (gone_r == '0) begin
            up_nxt    = 1'b1;
            j_nxt     = cnt_r - CW'(1);
            state_nxt = (cnt_r > pos_r) ? ifr_pkg::S_MVRD : ifr_pkg::S_PUT;
          end else begin
            up_nxt    = 1'b0;
            j_nxt     = pos_r + gone_r;
            state_nxt = ((pos_r + gone_r) < cnt_r) ? ifr_pkg::S_MVRD : ifr_pkg::S_PUT;
          end
        end
      end
      ifr_pkg::S_MVRD: begin
        state_nxt = ifr_pkg::S_MVWR;
      end
      ifr_pkg::S_MVWR: begin
        frag_we    = 1'b1;
        frag_waddr = {slot_r, dst[FW-1:0]};
        frag_wdata = {rd_start, rd_len};
        if (trim_en_r && j_r == (pos_r + gone_r) && {1'b0, rd_start} < e_r) begin
          frag_wdata = {rd_start + tr_amt, rd_len - tr_amt};
          bytes_nxt  = bytes_r - BW'(tr_amt);
        end
        if (up_r) begin
          if (j_r == pos_r) begin
            state_nxt = ifr_pkg::S_PUT;
          end else begin
            j_nxt     = j_r - CW'(1);
            state_nxt = ifr_pkg::S_MVRD;
          end
        end else begin
          if (j_r == cnt_r - CW'(1)) begin
            state_nxt = ifr_pkg::S_PUT;
          end else begin
            j_nxt     = j_r + CW'(1);
            state_nxt = ifr_pkg::S_MVRD;
          end
        end
      end
      ifr_pkg::S_PUT: begin
        frag_we   = 1'b1;
        cnt_nxt   = cnt_r - gone_r + CW'(1);
        bytes_nxt = bytes_r + BW'(ln_r);
        if (!mf_r) begin
          total_nxt = e_r;
          last_nxt  = 1'b1;
        end
        state_nxt = ifr_pkg::S_CHK0;
      end
      ifr_pkg::S_CHK0: begin
        j_nxt   = '0;
        exp_nxt = '0;
        if (last_r && bytes_r == BW'(total_r) && cnt_r != '0) begin
          state_nxt = ifr_pkg::S_CRD;
        end else begin
          state_nxt = ifr_pkg::S_FIN;
        end
      end
      ifr_pkg::S_CRD: begin
        state_nxt = ifr_pkg::S_CCHK;
      end
      ifr_pkg::S_CCHK: begin
        if ({1'b0, rd_start} != exp_r) begin
          if (j_r != '0) begin
            valid_nxt[slot_r] = 1'b0;
            corrupt_nxt       = 1'b1;
          end
          state_nxt = ifr_pkg::S_FIN;
        end else if (j_r == cnt_r - CW'(1)) begin
          valid_nxt[slot_r] = 1'b0;
          done_nxt          = 1'b1;
          state_nxt         = ifr_pkg::S_FIN;
        end else begin
          exp_nxt   = rd_end;
          j_nxt     = j_r + CW'(1);
          state_nxt = ifr_pkg::S_CRD;
        end
      end
      ifr_pkg::S_FIN: begin
        meta_we       = 1'b1;
        o_status_nxt  = done_r ? ifr_pkg::STATUS_DONE : ifr_pkg::STATUS_FRAG;
        o_total_nxt   = done_r ? total_r : 17'd0;
        o_slot_nxt    = 8'(slot_r);
        o_corrupt_nxt = corrupt_r;
        o_full_nxt    = full_r;
        state_nxt     = ifr_pkg::S_OUT;
      end
      ifr_pkg::S_OUT: begin
        if (out_ready) begin
          state_nxt = ifr_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ifr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ifr_pkg::S_IDLE;
      mode_r  <= ifr_pkg::MODE_FIRST;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    mf_r         <= mf_nxt;
    id_r         <= id_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    off_r        <= off_nxt;
    plen_r       <= plen_nxt;
    k_r          <= k_nxt;
    slot_r       <= slot_nxt;
    free_r       <= free_nxt;
    free_found_r <= free_found_nxt;
    cnt_r        <= cnt_nxt;
    pos_r        <= pos_nxt;
    j_r          <= j_nxt;
    gone_r       <= gone_nxt;
    bytes_r      <= bytes_nxt;
    removed_r    <= removed_nxt;
    total_r      <= total_nxt;
    prev_end_r   <= prev_end_nxt;
    e_r          <= e_nxt;
    exp_r        <= exp_nxt;
    last_r       <= last_nxt;
    have_cur_r   <= have_cur_nxt;
    cur_start_r  <= cur_start_nxt;
    cur_len_r    <= cur_len_nxt;
    st_r         <= st_nxt;
    ln_r         <= ln_nxt;
    trim_en_r    <= trim_en_nxt;
    up_r         <= up_nxt;
    done_r       <= done_nxt;
    corrupt_r    <= corrupt_nxt;
    full_r       <= full_nxt;
    o_status_r   <= o_status_nxt;
    o_total_r    <= o_total_nxt;
    o_slot_r     <= o_slot_nxt;
    o_corrupt_r  <= o_corrupt_nxt;
    o_full_r     <= o_full_nxt;
  end

  // stream keys
  ifr_ram #(.W(KW), .D(STREAMS), .AW(SW)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (free_now),
    .wdata ({id_r, lo_r, hi_r}),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  // per-stream count, byte sum, datagram length, last flag
  ifr_ram #(.W(MW), .D(STREAMS), .AW(SW)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (slot_r),
    .wdata ({cnt_r, bytes_r, total_r, last_r}),
    .raddr (slot_r),
    .rdata (meta_rdata)
  );

  // sorted fragment tables, one row per stream
  ifr_ram #(.W(32), .D(1 << FAW), .AW(FAW)) u_frag_ram (
    .clk   (clk),
    .we    (frag_we),
    .waddr (frag_waddr),
    .wdata (frag_wdata),
    .raddr (frag_raddr),
    .rdata (frag_rdata)
  );

  assign in_ready            = (state_r == ifr_pkg::S_IDLE);
  assign out_valid           = (state_r == ifr_pkg::S_OUT);
  assign cfg_ready           = 1'b1;
  assign out_status          = o_status_r;
  assign out_total_length    = o_total_r;
  assign out_stream_slot     = o_slot_r;
  assign out_corrupt_dropped = o_corrupt_r;
  assign out_table_full      = o_full_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result word is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready did not drop after accept");

  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ifr_pkg::STATUS_DONE) |->
      (!out_corrupt_dropped && !out_table_full))
    else $error("reassembled word carries an error flag");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_table_full || out_corrupt_dropped)) |->
      (out_status == ifr_pkg::STATUS_FRAG))
    else $error("drop flag with wrong status");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// ipv4 fragment reassembly tracker testbench
// Drives fragment, remove and clear words, predicts each result word from a
// behavioral copy of the stream and fragment tables, and compares every field.
// Runs every overlap policy, random idling on both sides and a long receiver
// hold-off that backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int NSTR = 16;
  localparam int NFRG = 16;
  localparam int NKEYS = 24;
  localparam int WATCHDOG = 5000;
  localparam int SETTLE = 300;

  typedef struct {
    logic [1:0]  func;
    logic        pay;
    logic [15:0] ident;
    logic [31:0] src;
    logic [31:0] dst;
    logic [12:0] off;
    logic [15:0] plen;
    logic        mf;
  } frag_word_t;

  typedef struct {
    logic [1:0]  status;
    logic [16:0] total;
    logic [7:0]  slot;
    logic        corrupt;
    logic        full;
  } verdict_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_func = '0;
  logic in_has_ip_payload = 0;
  logic [15:0] in_ident = '0;
  logic [31:0] in_src_addr = '0;
  logic [31:0] in_dst_addr = '0;
  logic [12:0] in_frag_offset = '0;
  logic [15:0] in_payload_len = '0;
  logic in_more_fragments = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] out_status;
  logic [16:0] out_total_length;
  logic [7:0] out_stream_slot;
  logic out_corrupt_dropped;
  logic out_table_full;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_overlap_mode = '0;

  ipv4_fragment_reassembly_tracker uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_has_ip_payload(in_has_ip_payload), .in_ident(in_ident),
    .in_src_addr(in_src_addr), .in_dst_addr(in_dst_addr),
    .in_frag_offset(in_frag_offset), .in_payload_len(in_payload_len),
    .in_more_fragments(in_more_fragments),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_total_length(out_total_length), .out_stream_slot(out_stream_slot),
    .out_corrupt_dropped(out_corrupt_dropped), .out_table_full(out_table_full),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_overlap_mode(cfg_overlap_mode)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // tracker copy
  logic [1:0] pol_mode;
  bit sv[NSTR];
  int unsigned sid[NSTR], slo[NSTR], shi[NSTR], fcnt[NSTR];
  int unsigned fst[NSTR][NFRG], fln[NSTR][NFRG];
  int unsigned brx[NSTR], dtot[NSTR];
  bit lseen[NSTR];

  verdict_t pending[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int n_done = 0, n_corrupt = 0, n_full = 0;
  bit steady = 0;
  bit hold_req = 0;
  int hold_cnt = 0;
  int quiet = 0;

  logic [15:0] kid[NKEYS];
  logic [31:0] ksrc[NKEYS], kdst[NKEYS];

  function automatic int find_stream(int unsigned id, int unsigned lo, int unsigned hi);
    for (int s = 0; s < NSTR; s++)
      if (sv[s] && sid[s] == id && slo[s] == lo && shi[s] == hi) return s;
    return -1;
  endfunction

  function automatic void put_entry(int s, int unsigned pos, int unsigned st, int unsigned ln);
    for (int k = fcnt[s]; k > int'(pos); k--) begin
      fst[s][k] = fst[s][k-1];
      fln[s][k] = fln[s][k-1];
    end
    fst[s][pos] = st;
    fln[s][pos] = ln;
    fcnt[s]++;
  endfunction

  function automatic void drop_entry(int s, int unsigned pos);
    for (int k = pos; k + 1 < int'(fcnt[s]); k++) begin
      fst[s][k] = fst[s][k+1];
      fln[s][k] = fln[s][k+1];
    end
    fcnt[s]--;
  endfunction

  function automatic verdict_t predict_verdict(frag_word_t w);
    verdict_t r;
    int unsigned off, plen, lo, hi, n, pos, prev_end, st, ln, amt, e, gone, expect_at;
    int s, j;
    bit same, gap;
    r = '{default: '0};
    off = w.off * 8;
    plen = w.plen;
    lo = (w.src < w.dst) ? w.src : w.dst;
    hi = (w.src < w.dst) ? w.dst : w.src;
    if (w.func == ifr_pkg::FUNC_CLEAR) begin
      for (int k = 0; k < NSTR; k++) sv[k] = 0;
      return r;
    end
    if (w.func == ifr_pkg::FUNC_REMOVE) begin
      s = find_stream(w.ident, lo, hi);
      if (s >= 0) begin
        sv[s] = 0;
        r.slot = 8'(s);
      end
      return r;
    end
    if (w.func != ifr_pkg::FUNC_FRAG || !w.pay || (!w.mf && off == 0)) return r;
    r.status = ifr_pkg::STATUS_FRAG;
    s = find_stream(w.ident, lo, hi);
    if (s < 0) begin
      for (s = 0; s < NSTR; s++) if (!sv[s]) break;
      if (s >= NSTR) begin
        r.full = 1;
        return r;
      end
      sv[s] = 1; sid[s] = w.ident; slo[s] = lo; shi[s] = hi;
      fcnt[s] = 0; brx[s] = 0; dtot[s] = 0; lseen[s] = 0;
    end
    r.slot = 8'(s);
    n = fcnt[s];
    pos = 0;
    prev_end = 0;
    while (pos < n && off > fst[s][pos]) begin
      prev_end = fst[s][pos] + fln[s][pos];
      pos++;
    end
    if (pol_mode == ifr_pkg::MODE_LINUX) begin
      if (pos < n && fst[s][pos] == off && fln[s][pos] == plen) begin
        if (!w.mf) begin dtot[s] = off + plen; lseen[s] = 1; end
      end else begin
        st = off;
        ln = plen;
        if (prev_end > st) begin
          amt = (prev_end - st < ln) ? prev_end - st : ln;
          st += amt;
          ln -= amt;
        end
        if (ln != 0 && st + ln <= 65535) begin
          e = st + ln;
          gone = 0;
          for (j = pos; j < n && fst[s][j] < e && fst[s][j] + fln[s][j] <= e; j++) gone++;
          if (n - gone >= NFRG) begin
            r.full = 1;
            return r;
          end
          while (pos < fcnt[s] && fst[s][pos] < e) begin
            amt = (e - fst[s][pos] < fln[s][pos]) ? e - fst[s][pos] : fln[s][pos];
            fst[s][pos] += amt;
            fln[s][pos] -= amt;
            brx[s] -= amt;
            if (fln[s][pos] == 0) drop_entry(s, pos);
            else break;
          end
          put_entry(s, pos, st, ln);
          brx[s] += ln;
          if (!w.mf) begin dtot[s] = e; lseen[s] = 1; end
        end
      end
    end else begin
      same = pos < n && fst[s][pos] == off;
      if (same && pol_mode == ifr_pkg::MODE_LAST) begin
        brx[s] = brx[s] - fln[s][pos] + plen;
        fln[s][pos] = plen;
        if (!w.mf) begin dtot[s] = off + plen; lseen[s] = 1; end
      end else if (!same) begin
        if (n >= NFRG) begin
          r.full = 1;
          return r;
        end
        put_entry(s, pos, off, plen);
        brx[s] += plen;
        if (!w.mf) begin dtot[s] = off + plen; lseen[s] = 1; end
      end
    end
    n = fcnt[s];
    if (lseen[s] && brx[s] == dtot[s] && n > 0 && fst[s][0] == 0) begin
      expect_at = 0;
      gap = 0;
      for (int k = 0; k < n; k++) begin
        if (fst[s][k] != expect_at) begin gap = 1; break; end
        expect_at = fst[s][k] + fln[s][k];
      end
      sv[s] = 0;
      if (gap) r.corrupt = 1;
      else begin
        r.status = ifr_pkg::STATUS_DONE;
        r.total = 17'(dtot[s]);
      end
    end
    return r;
  endfunction

  task automatic send_word(frag_word_t w);
    while (!steady && $urandom_range(99) < 32) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_func <= w.func;
    in_has_ip_payload <= w.pay;
    in_ident <= w.ident;
    in_src_addr <= w.src;
    in_dst_addr <= w.dst;
    in_frag_offset <= w.off;
    in_payload_len <= w.plen;
    in_more_fragments <= w.mf;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending.push_back(predict_verdict(w));
    words_sent++;
  endtask

  task automatic send_frag(int k, int unsigned off, int unsigned plen, bit mf);
    frag_word_t w;
    bit flip;
    flip = 1'($urandom_range(1));
    w = '{func: ifr_pkg::FUNC_FRAG, pay: 1'b1, ident: kid[k],
          src: flip ? kdst[k] : ksrc[k], dst: flip ? ksrc[k] : kdst[k],
          off: 13'(off), plen: 16'(plen), mf: mf};
    send_word(w);
  endtask

  task automatic send_cmd(logic [1:0] f, int k);
    frag_word_t w;
    w = '{func: f, pay: 1'($urandom_range(1)), ident: kid[k], src: ksrc[k], dst: kdst[k],
          off: 13'($urandom), plen: 16'($urandom), mf: 1'($urandom_range(1))};
    send_word(w);
  endtask

  task automatic write_mode(logic [1:0] m);
    in_valid <= 0;
    wait (pending.size() == 0);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1;
    cfg_overlap_mode <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    pol_mode = m;
  endtask

  task automatic test_basic_words;
    frag_word_t w;
    write_mode(ifr_pkg::MODE_FIRST);
    w = '{func: ifr_pkg::FUNC_FRAG, pay: 0, ident: 16'hffff, src: '1, dst: '0, off: '1,
          plen: '1, mf: 1};
    send_word(w);
    w = '{func: ifr_pkg::FUNC_FRAG, pay: 1, ident: 0, src: 0, dst: '1, off: 0, plen: '1,
          mf: 0};
    send_word(w);
    w.func = 2'd3;
    send_word(w);
    send_cmd(ifr_pkg::FUNC_REMOVE, 0);
    send_cmd(ifr_pkg::FUNC_CLEAR, 0);
    // two fragment datagram in order, then reversed
    send_frag(0, 0, 16, 1);
    send_frag(0, 2, 5, 0);
    send_frag(1, 1, 9, 0);
    send_frag(1, 0, 8, 1);
    // highest offset with longest payload
    send_frag(2, 13'h1fff, 16'hffff, 0);
    send_cmd(ifr_pkg::FUNC_REMOVE, 2);
    // overlap that leaves a gap once complete
    send_frag(3, 0, 16, 1);
    send_frag(3, 1, 16, 1);
    send_frag(3, 4, 8, 0);
  endtask

  task automatic test_stream_table_full;
    for (int k = 0; k <= NSTR; k++) send_frag(k, 1, 8, 1);
    send_cmd(ifr_pkg::FUNC_CLEAR, 0);
  endtask

  task automatic test_fragment_table_full;
    for (int i = 1; i <= NFRG + 1; i++) send_frag(4, i, 8, 1);
    send_frag(4, 0, 8, 1);
    send_cmd(ifr_pkg::FUNC_REMOVE, 4);
  endtask

  task automatic test_linux_cases;
    write_mode(ifr_pkg::MODE_LINUX);
    send_frag(5, 0, 24, 1);
    send_frag(5, 0, 24, 1);
    send_frag(5, 1, 8, 1);
    send_frag(5, 2, 16, 1);
    send_frag(5, 8000, 16'hffff, 0);
    send_frag(5, 4, 8, 0);
  endtask

  task automatic run_datagram(int k);
    int unsigned offs[24], lens[24];
    bit mfs[24];
    int n, cur, u, j, t;
    bit b;
    n = $urandom_range(1, 5);
    if ($urandom_range(24) == 0) n = 18;
    cur = 0;
    for (int i = 0; i < n; i++) begin
      u = $urandom_range(1, 4);
      offs[i] = cur;
      lens[i] = u * 8;
      mfs[i] = 1;
      cur += u;
    end
    lens[n-1] = $urandom_range(1, 40);
    mfs[n-1] = 0;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = offs[i]; offs[i] = offs[j]; offs[j] = t;
      t = lens[i]; lens[i] = lens[j]; lens[j] = t;
      b = mfs[i]; mfs[i] = mfs[j]; mfs[j] = b;
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 15)
        send_frag(k, offs[i] + $urandom_range(2), $urandom_range(1, 40), 1);
      if ($urandom_range(99) < 4) continue;
      send_frag(k, offs[i], lens[i], mfs[i]);
    end
  endtask

  task automatic run_random_phase(int count);
    frag_word_t w;
    int start;
    start = words_sent;
    while (words_sent - start < count) begin
      case ($urandom_range(9))
        0: begin
          w.func = 2'($urandom); w.pay = 1'($urandom); w.ident = 16'($urandom);
          w.src = $urandom; w.dst = $urandom; w.off = 13'($urandom);
          w.plen = 16'($urandom); w.mf = 1'($urandom);
          send_word(w);
        end
        1: send_cmd($urandom_range(7) == 0 ? ifr_pkg::FUNC_CLEAR : ifr_pkg::FUNC_REMOVE,
                    $urandom_range(NKEYS - 1));
        default: run_datagram($urandom_range(NKEYS - 1));
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (hold_req) begin
      hold_cnt = 400;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 0;
    end else begin
      out_ready <= steady || $urandom_range(99) >= 32;
    end
  end

  always @(posedge clk) begin
    verdict_t e;
    if (out_valid && out_ready) begin
      words_checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word status %0d", out_status);
      end else begin
        e = pending.pop_front();
        if (out_status == ifr_pkg::STATUS_DONE) n_done++;
        n_corrupt += out_corrupt_dropped;
        n_full += out_table_full;
        if (out_status !== e.status || out_total_length !== e.total ||
            out_stream_slot !== e.slot || out_corrupt_dropped !== e.corrupt ||
            out_table_full !== e.full) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp st=%0d len=%0d slot=%0d cd=%0d tf=%0d got st=%0d len=%0d slot=%0d cd=%0d tf=%0d",
                     e.status, e.total, e.slot, e.corrupt, e.full, out_status,
                     out_total_length, out_stream_slot, out_corrupt_dropped, out_table_full);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || !rst_n)
      quiet = 0;
    else
      quiet++;
    if (quiet >= WATCHDOG) begin
      $display("watchdog expired, %0d results outstanding", pending.size());
      $display("FAIL ipv4_fragment_reassembly_tracker");
      $finish;
    end
  end

  initial begin
    pol_mode = ifr_pkg::MODE_FIRST;
    for (int s = 0; s < NSTR; s++) begin
      sv[s] = 0; fcnt[s] = 0; brx[s] = 0; dtot[s] = 0; lseen[s] = 0;
    end
    for (int k = 0; k < NKEYS; k++) begin
      kid[k] = 16'($urandom);
      ksrc[k] = $urandom;
      kdst[k] = $urandom;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_basic_words();
    test_stream_table_full();
    test_fragment_table_full();
    test_linux_cases();
    write_mode(ifr_pkg::MODE_FIRST);
    run_random_phase(180);
    write_mode(ifr_pkg::MODE_LAST);
    steady = 1;
    run_random_phase(150);
    steady = 0;
    write_mode(ifr_pkg::MODE_LINUX);
    hold_req = 1;
    run_random_phase(250);
    write_mode(2'd3);
    run_random_phase(80);
    write_mode(ifr_pkg::MODE_LAST);
    run_random_phase(150);
    write_mode(ifr_pkg::MODE_LINUX);
    run_random_phase(150);
    in_valid <= 0;
    wait (pending.size() == 0);
    repeat (SETTLE) @(posedge clk);
    $display("sent %0d words over all overlap policies, checked %0d results", words_sent,
             words_checked);
    $display("reassembled %0d, corrupt %0d, table full %0d, mismatches %0d", n_done,
             n_corrupt, n_full, errors);
    if (errors == 0) begin
      $display("PASS ipv4_fragment_reassembly_tracker");
    end else begin
      $display("FAIL ipv4_fragment_reassembly_tracker");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/ifr_pkg.sv
rtl/core/ifr_ram.sv
rtl/core/ipv4_fragment_reassembly_tracker.sv
tb/testbench.sv
